// ===== hdl/mdf_pkg.sv =====
package mdf_pkg;

  localparam int HEADER_BYTES = 21;
  localparam int ALIGN_BYTES_DEF = 4;

  localparam logic [7:0] PAD_BYTE = 8'hFF;

  // header byte offsets
  localparam int IDX_LEN_HI = 1;
  localparam int IDX_LEN_LO = 2;
  localparam int IDX_DEST = 3;
  localparam int IDX_SRC = 11;
  localparam int IDX_TYPE = 19;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_TRUNC_HDR = 3'd1;
  localparam logic [2:0] ST_TRUNC_PAY = 3'd2;
  localparam logic [2:0] ST_NO_MSG = 3'd3;
  localparam logic [2:0] ST_BAD_PAD = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  msg_flags;
    logic [15:0] payload_length;
    logic [63:0] dest_id;
    logic [63:0] src_id;
    logic [7:0]  proto_type;
    logic [7:0]  proto_port;
    logic [7:0]  payload_byte;
    logic        payload_end;
    logic        done_res;
    logic [2:0]  status;
  } mdf_result_t;

endpackage

// ===== hdl/mdf_core.sv =====
module mdf_core #(
  parameter int ALIGN_BYTES = mdf_pkg::ALIGN_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          byte_in,
  input  logic                last_in,
  output logic                emit,
  output mdf_pkg::mdf_result_t res
);

  localparam int HB = mdf_pkg::HEADER_BYTES;
  localparam int HPW = $clog2(HB);
  localparam int PW = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
  localparam logic [HPW-1:0] HPOS_LAST = HPW'(HB - 1);
  localparam logic [PW-1:0] POS_LAST = PW'(ALIGN_BYTES - 1);
  localparam logic [PW-1:0] HDR_MOD = PW'(HB % ALIGN_BYTES);

  localparam logic [1:0] PH_HDR = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_PADRUN = 2'd2;
  localparam logic [1:0] PH_DRAIN = 2'd3;

  logic [1:0]     phase_r, phase_nxt;
  logic [HPW-1:0] hpos_r, hpos_nxt;
  logic [15:0]    pay_left_r, pay_left_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic           seen_r, seen_nxt;
  logic           allpad_r, allpad_nxt;
  logic [2:0]     pend_r, pend_nxt;
  logic           hdr_we;

  // last header byte is taken straight from the input, so it is not stored
  logic [7:0] hdr_r [HB-1];

  logic [15:0] len;
  logic [63:0] dest;
  logic [63:0] src;
  logic [2:0]  none_st;

  always_comb begin
    len = {hdr_r[mdf_pkg::IDX_LEN_HI], hdr_r[mdf_pkg::IDX_LEN_LO]};
    dest = '0;
    src = '0;
    for (int i = 0; i < 8; i++) begin
      dest = {dest[55:0], hdr_r[mdf_pkg::IDX_DEST + i]};
      src = {src[55:0], hdr_r[mdf_pkg::IDX_SRC + i]};
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    hpos_nxt = hpos_r;
    pay_left_nxt = pay_left_r;
    pos_nxt = pos_r;
    seen_nxt = seen_r;
    allpad_nxt = allpad_r;
    pend_nxt = pend_r;
    hdr_we = 1'b0;
    emit = 1'b0;
    res = '0;
    none_st = mdf_pkg::ST_OK;

    unique case (phase_r)
      PH_HDR: begin
        hdr_we = (hpos_r != HPOS_LAST);
        allpad_nxt = allpad_r & (byte_in == mdf_pkg::PAD_BYTE);
        if (hpos_r == HPOS_LAST) begin
          hpos_nxt = '0;
          if (allpad_nxt) begin
            phase_nxt = PH_PADRUN;
          end else begin
            emit = 1'b1;
            res.kind = mdf_pkg::KIND_HEADER;
            res.msg_flags = hdr_r[0];
            res.payload_length = len;
            res.dest_id = dest;
            res.src_id = src;
            res.proto_type = hdr_r[mdf_pkg::IDX_TYPE];
            res.proto_port = byte_in;
            allpad_nxt = 1'b1;
            if (len == '0 && HDR_MOD == '0) begin
              seen_nxt = 1'b1;
            end else begin
              phase_nxt = PH_BODY;
              pay_left_nxt = len;
              pos_nxt = HDR_MOD;
            end
          end
        end else begin
          hpos_nxt = hpos_r + 1'b1;
        end
      end
      PH_BODY: begin
        if (pay_left_r != '0) begin
          emit = 1'b1;
          res.kind = mdf_pkg::KIND_PAYLOAD;
          res.payload_byte = byte_in;
          res.payload_end = (pay_left_r == 16'd1);
          pay_left_nxt = pay_left_r - 1'b1;
        end
        pos_nxt = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
        // message ends on the alignment boundary once the payload is out
        if (pay_left_nxt == '0 && pos_nxt == '0) begin
          phase_nxt = PH_HDR;
          hpos_nxt = '0;
          allpad_nxt = 1'b1;
          seen_nxt = 1'b1;
        end
      end
      PH_PADRUN: begin
        if (byte_in != mdf_pkg::PAD_BYTE) begin
          phase_nxt = PH_DRAIN;
          pend_nxt = mdf_pkg::ST_BAD_PAD;
        end
      end
      PH_DRAIN: begin
      end
      default: begin
      end
    endcase

    if (last_in) begin
      if (!emit) begin
        res.kind = mdf_pkg::KIND_STATUS;
      end
      emit = 1'b1;
      res.done_res = 1'b1;
      none_st = seen_nxt ? mdf_pkg::ST_OK : mdf_pkg::ST_NO_MSG;
      unique case (phase_nxt)
        PH_DRAIN:  res.status = pend_nxt;
        PH_BODY:   res.status = mdf_pkg::ST_TRUNC_PAY;
        PH_PADRUN: res.status = none_st;
        default:   res.status = (hpos_nxt == '0 || allpad_nxt) ? none_st
                                                               : mdf_pkg::ST_TRUNC_HDR;
      endcase
      // input over: back to the reset state
      phase_nxt = PH_HDR;
      hpos_nxt = '0;
      pay_left_nxt = '0;
      pos_nxt = '0;
      seen_nxt = 1'b0;
      allpad_nxt = 1'b1;
      pend_nxt = mdf_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      hpos_r <= '0;
      pay_left_r <= '0;
      pos_r <= '0;
      seen_r <= 1'b0;
      allpad_r <= 1'b1;
      pend_r <= mdf_pkg::ST_OK;
    end else if (step) begin
      phase_r <= phase_nxt;
      hpos_r <= hpos_nxt;
      pay_left_r <= pay_left_nxt;
      pos_r <= pos_nxt;
      seen_r <= seen_nxt;
      allpad_r <= allpad_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && hdr_we) begin
      hdr_r[hpos_r] <= byte_in;
    end
  end

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_in |-> emit && res.done_res)
    else $error("final byte gave no status result");

  a_end_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
    res.payload_end |-> res.kind == mdf_pkg::KIND_PAYLOAD)
    else $error("payload_end outside a payload result");

  a_body_hpos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> hpos_r == '0)
    else $error("header position not cleared in body");

  a_drain_err: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_PADRUN && byte_in != mdf_pkg::PAD_BYTE && !last_in
      |=> phase_r == PH_DRAIN && pend_r == mdf_pkg::ST_BAD_PAD)
    else $error("bad padding not latched");

endmodule

// ===== hdl/mdf_out_reg.sv =====
module mdf_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  mdf_pkg::mdf_result_t res,
  input  logic                 stall,
  output logic                 ready,
  output logic                 valid,
  output mdf_pkg::mdf_result_t data
);

  logic                 valid_r;
  mdf_pkg::mdf_result_t data_r;

  // free when empty or the held result is being transferred
  assign ready = !valid_r || !stall;
  assign valid = valid_r;
  assign data = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      data_r <= res;
    end
  end

endmodule

// ===== hdl/message_deframer.sv =====
// A byte passes through the input register and then the result register.
// Throughput: one byte per cycle, unless out_stall holds the result register.
// The last header byte, each payload byte and the final byte give one result;
// other header bytes, fill and padding give none. rst_n is synchronous, active
// low; it empties both registers and returns the parser to a message boundary. The header store needs no clearing.
module message_deframer #(
  parameter int ALIGN_BYTES = mdf_pkg::ALIGN_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_msg_flags,
  output logic [15:0] out_payload_length,
  output logic [63:0] out_dest_id,
  output logic [63:0] out_src_id,
  output logic [7:0]  out_proto_type,
  output logic [7:0]  out_proto_port,
  output logic [7:0]  out_payload_byte,
  output logic        out_payload_end,
  output logic        out_done_res,
  output logic [2:0]  out_status
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       adv;
  logic       step;
  logic       emit;

  mdf_pkg::mdf_result_t res;
  mdf_pkg::mdf_result_t out_data;

  assign in_stall = in_valid_r && !adv;
  assign step = in_valid_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_byte;
      in_last_r <= in_last;
    end
  end

  mdf_core #(
    .ALIGN_BYTES(ALIGN_BYTES)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .byte_in(in_byte_r),
    .last_in(in_last_r),
    .emit   (emit),
    .res    (res)
  );

  mdf_out_reg u_out (
    .clk  (clk),
    .rst_n(rst_n),
    .load (step && emit),
    .res  (res),
    .stall(out_stall),
    .ready(adv),
    .valid(out_valid),
    .data (out_data)
  );

  assign out_kind = out_data.kind;
  assign out_msg_flags = out_data.msg_flags;
  assign out_payload_length = out_data.payload_length;
  assign out_dest_id = out_data.dest_id;
  assign out_src_id = out_data.src_id;
  assign out_proto_type = out_data.proto_type;
  assign out_proto_port = out_data.proto_port;
  assign out_payload_byte = out_data.payload_byte;
  assign out_payload_end = out_data.payload_end;
  assign out_done_res = out_data.done_res;
  assign out_status = out_data.status;

endmodule
